// ===== src/mtrg_pkg.sv =====
package mtrg_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH = 2'd2;

    localparam logic [WORD_W-1:0] KNUTH_MUL    = 32'd1812433253;
    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

    localparam logic [WORD_W-1:0] SEED_RESET = 32'h0000_0000;
    localparam logic [WORD_W-1:0] LOW_RESET  = 32'h0000_0000;
    localparam logic [WORD_W-1:0] HIGH_RESET = 32'hffff_ffff;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } t_mod_req;

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
        logic [WORD_W-1:0] y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ===== src/mtrg_mod.sv =====
module mtrg_mod (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mtrg_pkg::t_mod_req                  i_req,
    output logic                                o_done,
    output logic [mtrg_pkg::WORD_W-1:0]         o_rem
);
    import mtrg_pkg::*;

    localparam int unsigned CNT_W = $clog2(WORD_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [WORD_W-1:0] r_rem, n_rem;
    logic [WORD_W-1:0] r_dvd, n_dvd;
    logic [WORD_W-1:0] r_dvs, n_dvs;
    logic [WORD_W:0]   trial;

    // one quotient bit per cycle, MSB first
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        trial  = {r_rem, r_dvd[WORD_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvd  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = WORD_W'(trial - {1'b0, r_dvs});
            end else begin
                n_rem = trial[WORD_W-1:0];
            end
            n_dvd = r_dvd << 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(WORD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

`ifndef NO_ASSERTIONS
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("remainder done while still iterating");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("remainder start while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy))
        else $error("remainder done without a run");
`endif

endmodule

// ===== src/mt19937_ranged_generator.sv =====
// channel | direction | handshake                 | payload
// in      | input     | i_in_valid / o_in_stall   | i_restart
// out     | output    | o_out_valid / i_out_stall | o_raw_word, o_ranged_value
// cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A draw steps through S_READ, S_TWIST, S_DIV and S_DONE; the bit-serial remainder unit
// in S_DIV dominates the latency, and a full-range span (span of zero) skips it.
// Restart, and the first draw after reset, seed the state first in S_SEED.
// Reset is synchronous, active low; the state memory is not cleared.
// The input is stalled while a draw is in flight; the result waits in an output register,
// so the next draw is taken while the previous transaction is stalled.
module mt19937_ranged_generator #(
    parameter int unsigned STATE_DEPTH  = 624,
    parameter int unsigned SHIFT_OFFSET = 397
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_restart,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [mtrg_pkg::WORD_W-1:0]         o_raw_word,
    output logic [mtrg_pkg::WORD_W-1:0]         o_ranged_value,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mtrg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mtrg_pkg::WORD_W-1:0]         i_cfg_data
);
    import mtrg_pkg::*;

    localparam int unsigned ADDR_W = $clog2(STATE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_DEPTH - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SEED  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_TWIST = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic              r_seeded, n_seeded;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [ADDR_W-1:0] r_k, n_k;
    logic [WORD_W-1:0] r_prev, n_prev;
    logic [WORD_W-1:0] r_cur, n_cur;
    logic [WORD_W-1:0] r_raw, n_raw;
    logic [WORD_W-1:0] r_ranged, n_ranged;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_raw, r_out_ranged;
    logic [WORD_W-1:0] r_seed_value, r_range_low, r_range_high;

    logic [WORD_W-1:0] r_mem [STATE_DEPTH];
    logic [WORD_W-1:0] r_rd_nxt, r_rd_far;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    logic              in_accept, out_take, out_free;
    logic [ADDR_W-1:0] nxt_addr, far_addr;
    logic [ADDR_W:0]   far_sum;
    logic [WORD_W-1:0] seed_mix, seed_word;
    logic [WORD_W-1:0] mixed, twist_word, tempered, span;
    t_mod_req          mod_req;
    logic              mod_done;
    logic [WORD_W-1:0] mod_rem;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_value <= SEED_RESET;
            r_range_low  <= LOW_RESET;
            r_range_high <= HIGH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SEED: r_seed_value <= i_cfg_data;
                REG_LOW:  r_range_low  <= i_cfg_data;
                REG_HIGH: r_range_high <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // neighbors of the word being twisted
    always_comb begin
        nxt_addr = (r_pos == LAST_ADDR) ? '0 : r_pos + 1'b1;
        far_sum  = {1'b0, r_pos} + (ADDR_W+1)'(SHIFT_OFFSET);
        if (far_sum >= (ADDR_W+1)'(STATE_DEPTH)) begin
            far_addr = ADDR_W'(far_sum - (ADDR_W+1)'(STATE_DEPTH));
        end else begin
            far_addr = far_sum[ADDR_W-1:0];
        end
    end

    assign seed_mix  = r_prev ^ (r_prev >> 30);
    assign seed_word = KNUTH_MUL * seed_mix + WORD_W'(r_k);

    // r_cur holds the current word at r_pos; r_rd_nxt feeds it for the next draw
    assign mixed      = {r_cur[WORD_W-1], r_rd_nxt[WORD_W-2:0]};
    assign twist_word = r_rd_far ^ (mixed >> 1) ^ (r_rd_nxt[0] ? TWIST_MATRIX : '0);
    assign tempered   = temper(twist_word);
    assign span       = r_range_high - r_range_low + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_seeded    = r_seeded;
        n_pos       = r_pos;
        n_k         = r_k;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_raw       = r_raw;
        n_ranged    = r_ranged;
        n_out_valid = out_take ? 1'b0 : r_out_valid;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = twist_word;
        mod_req     = '{start: 1'b0, dividend: tempered, divisor: span};
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_restart || !r_seeded) begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = r_seed_value;
                        n_prev    = r_seed_value;
                        n_cur     = r_seed_value;
                        n_k       = ADDR_W'(1);
                        n_pos     = '0;
                        n_seeded  = 1'b1;
                        n_state   = S_SEED;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_SEED: begin
                mem_we    = 1'b1;
                mem_waddr = r_k;
                mem_wdata = seed_word;
                n_prev    = seed_word;
                if (r_k == LAST_ADDR) begin
                    n_state = S_READ;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_READ: begin
                mem_re  = 1'b1;
                n_state = S_TWIST;
            end
            S_TWIST: begin
                mem_we = 1'b1;
                n_cur  = r_rd_nxt;
                n_pos  = nxt_addr;
                n_raw  = tempered;
                if (span == '0) begin
                    n_ranged = tempered + r_range_low;
                    n_state  = S_DONE;
                end else begin
                    mod_req.start = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (mod_done) begin
                    n_ranged = mod_rem + r_range_low;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                // hand over once the output register is free or being taken
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seeded    <= 1'b0;
            r_pos       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seeded    <= n_seeded;
            r_pos       <= n_pos;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev   <= n_prev;
        r_cur    <= n_cur;
        r_raw    <= n_raw;
        r_ranged <= n_ranged;
        if (r_state == S_DONE && out_free) begin
            r_out_raw    <= r_raw;
            r_out_ranged <= r_ranged;
        end
    end

    // state memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_nxt <= r_mem[nxt_addr];
            r_rd_far <= r_mem[far_addr];
        end
    end

    mtrg_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    assign o_out_valid    = r_out_valid;
    assign o_raw_word     = r_out_raw;
    assign o_ranged_value = r_out_ranged;

`ifndef NO_ASSERTIONS
    a_seeded_after_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_seeded)
        else $error("draw accepted but state left unseeded");
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_ADDR)
        else $error("read position beyond state depth");
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result shown without a finished draw");
    a_mod_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> r_state == S_DIV)
        else $error("remainder finished outside of the divide step");
`endif

endmodule
